@@ hdl/key_matrix_report_builder_defines.svh @@
// assertion macros shared by the key matrix report builder rtl
// no dependencies; included by files that carry concurrent checks
`ifndef KEY_MATRIX_REPORT_BUILDER_DEFINES_SVH
`define KEY_MATRIX_REPORT_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
`define KMRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmrb check failed");
`define KMRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmrb check failed");
`else
`define KMRB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KMRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/kmrb_pkg.sv @@
// shared types, constants and usage-code table of the key matrix report builder
// no dependencies
package kmrb_pkg;

    localparam int ROW_W      = 3;
    localparam int COL_LANES  = 5;
    localparam int CODE_W     = 8;
    localparam int OUT_SLOTS  = 6;
    localparam int POS_W      = 4;
    localparam int RANK_W     = 3;
    localparam int ROW_COUNT    = 5;
    localparam int COLUMN_COUNT = 5;
    localparam int TABLE_ROWS = 5;
    localparam int TABLE_COLS = 5;
    localparam int TABLE_SIZE = TABLE_ROWS * TABLE_COLS;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = OUT_SLOTS * CODE_W;

    localparam logic [CODE_W-1:0] USAGE_TABLE [TABLE_SIZE] = '{
        8'h4A, 8'h4D, 8'h4C, 8'h38, 8'h25,
        8'h4B, 8'h1E, 8'h1F, 8'h20, 8'h56,
        8'h4E, 8'h21, 8'h22, 8'h23, 8'h57,
        8'h52, 8'h24, 8'h25, 8'h26, 8'h28,
        8'h50, 8'h51, 8'h4F, 8'h27, 8'h37
    };

    typedef struct packed {
        logic              active;
        logic [CODE_W-1:0] code;
    } lane_hit_t;

    typedef logic [CODE_W-1:0] code_t;

    // key outside the table reads as no usage
    function automatic code_t usage_lookup(input logic [ROW_W-1:0] row,
                                           input logic [ROW_W-1:0] col);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'({2'b00, row} * TABLE_COLS) + IDX_W'(col);
        if (32'(row) >= TABLE_ROWS || 32'(col) >= TABLE_COLS) begin
            return '0;
        end
        return USAGE_TABLE[idx];
    endfunction

endpackage

@@ hdl/kmrb_lane.sv @@
// one column lane: looks up the usage code of its key in the sampled row
// depends on kmrb_pkg
module kmrb_lane #(
    parameter int LANE = 0
) (
    input  logic [kmrb_pkg::ROW_W-1:0] row_index,
    input  logic                       row_valid,
    input  logic                       column_bit,
    output kmrb_pkg::lane_hit_t        hit
);

    kmrb_pkg::code_t code;

    assign code = kmrb_pkg::usage_lookup(row_index, kmrb_pkg::ROW_W'(LANE));

    // a zero code never changes a slot, so it counts as no press
    assign hit.code   = code;
    assign hit.active = column_bit && row_valid && (LANE < kmrb_pkg::COLUMN_COUNT)
                        && (code != '0);

endmodule

@@ hdl/kmrb_merge.sv @@
// merge stage: ranks lane hits and drops them into the report slots
// depends on kmrb_pkg and the assertion macro header
`include "key_matrix_report_builder_defines.svh"

module kmrb_merge #(
    parameter int SLOT_COUNT = 6
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            accept,
    input  logic                                            row_valid,
    input  logic                                            frame_end,
    input  kmrb_pkg::lane_hit_t [kmrb_pkg::COL_LANES-1:0]   hits,
    output kmrb_pkg::code_t     [kmrb_pkg::OUT_SLOTS-1:0]   report
);

    localparam int FW = $clog2(SLOT_COUNT + 1);

    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    kmrb_pkg::code_t slot_reg  [SLOT_COUNT];
    kmrb_pkg::code_t slot_next [SLOT_COUNT];

    logic [kmrb_pkg::RANK_W-1:0] rank [kmrb_pkg::COL_LANES];
    logic [kmrb_pkg::RANK_W-1:0] hit_cnt;
    logic [kmrb_pkg::POS_W-1:0]  fill_sum;

    // rank of each lane among the pressed keys of this row
    always_comb begin
        hit_cnt = '0;
        for (int c = 0; c < kmrb_pkg::COL_LANES; c++) begin
            rank[c] = hit_cnt;
            hit_cnt = hit_cnt + kmrb_pkg::RANK_W'(hits[c].active);
        end
    end

    // slots fill as a prefix, so lane c lands at fill + rank
    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_next[s] = slot_reg[s];
            for (int c = 0; c < kmrb_pkg::COL_LANES; c++) begin
                if (hits[c].active && (kmrb_pkg::POS_W'(fill_reg) + kmrb_pkg::POS_W'(rank[c])
                                       == kmrb_pkg::POS_W'(s))) begin
                    slot_next[s] = hits[c].code;
                end
            end
        end
    end

    assign fill_sum  = kmrb_pkg::POS_W'(fill_reg) + kmrb_pkg::POS_W'(hit_cnt);
    assign fill_next = (fill_sum >= kmrb_pkg::POS_W'(SLOT_COUNT)) ? FW'(SLOT_COUNT)
                                                                  : fill_sum[FW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                slot_reg[s] <= '0;
            end
        end else if (accept && row_valid) begin
            if (frame_end) begin
                fill_reg <= '0;
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    slot_reg[s] <= '0;
                end
            end else begin
                fill_reg <= fill_next;
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    slot_reg[s] <= slot_next[s];
                end
            end
        end
    end

    // unused report slots read as empty
    for (genvar s = 0; s < kmrb_pkg::OUT_SLOTS; s++) begin : g_report
        if (s < SLOT_COUNT) begin : g_used
            assign report[s] = slot_next[s];
        end else begin : g_unused
            assign report[s] = '0;
        end
    end

    `KMRB_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, 32'(fill_reg) <= SLOT_COUNT)
    `KMRB_ASSERT_NEXT(a_frame_clears, aclk, aresetn, accept && row_valid && frame_end, fill_reg == '0)
    `KMRB_ASSERT_NEXT(a_bad_row_holds, aclk, aresetn, accept && !row_valid, $stable(fill_reg))
    `KMRB_ASSERT_IMP(a_empty_first, aclk, aresetn, fill_reg == '0, slot_reg[0] == '0)

endmodule

@@ hdl/key_matrix_report_builder.sv @@
// key matrix report builder top level: column lanes, slot merge, report register
// depends on kmrb_pkg, kmrb_lane, kmrb_merge and the assertion macro header
//
// usage:
//   the input channel (s_t*) carries one sampled matrix row per transaction:
//   the row number and the five column bits. each pressed column, lowest
//   first, is mapped to a usb hid usage code and goes into the first free of
//   six report slots; presses beyond a full report are dropped. rows outside
//   the matrix are ignored.
//   the row that ends a frame (the last matrix row) closes the report: the six
//   slots, including that row's presses, leave on the output channel (m_t*)
//   as one transaction and the slots clear for the next frame. other rows
//   give no output.
//   output: the report is valid on m_tvalid in the cycle after the last row is
//   accepted. throughput: one row per cycle while the report register is not
//   stalled; the lane lookup and slot merge handle all five columns at once.
//   stall: the report register holds until taken; while it is full and
//   m_tready is low, s_tready is low. when it is taken in the same cycle,
//   a new row is accepted at once.
//   reset: aresetn low clears the slots, the fill count and m_tvalid.
`include "key_matrix_report_builder_defines.svh"

module key_matrix_report_builder #(
    parameter int SLOT_COUNT = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // row_index [2:0], column_bits [7:3]
    input  logic [kmrb_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // slot_one [7:0], slot_two [15:8], slot_three [23:16],
    // slot_four [31:24], slot_five [39:32], slot_six [47:40]
    output logic [kmrb_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic [kmrb_pkg::ROW_W-1:0]     row_index;
    logic [kmrb_pkg::COL_LANES-1:0] column_bits;
    logic                           accept;
    logic                           row_valid;
    logic                           frame_end;

    kmrb_pkg::lane_hit_t [kmrb_pkg::COL_LANES-1:0] hits;
    kmrb_pkg::code_t     [kmrb_pkg::OUT_SLOTS-1:0] report;

    logic                               m_valid_reg;
    logic [kmrb_pkg::OUT_DATA_W-1:0]    m_data_reg;

    assign row_index   = s_tdata[kmrb_pkg::ROW_W-1:0];
    assign column_bits = s_tdata[kmrb_pkg::ROW_W +: kmrb_pkg::COL_LANES];

    // rows past the matrix are dropped; the last row closes the frame
    assign row_valid = 32'(row_index) < kmrb_pkg::ROW_COUNT;
    assign frame_end = 32'(row_index) == kmrb_pkg::ROW_COUNT - 1;

    // report register frees up in the cycle it is taken
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // one lane per column, all in parallel
    for (genvar c = 0; c < kmrb_pkg::COL_LANES; c++) begin : g_lane
        kmrb_lane #(
            .LANE (c)
        ) u_lane (
            .row_index  (row_index),
            .row_valid  (row_valid),
            .column_bit (column_bits[c]),
            .hit        (hits[c])
        );
    end

    kmrb_merge #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .row_valid (row_valid),
        .frame_end (frame_end),
        .hits      (hits),
        .report    (report)
    );

    // output register: loads the finished report, holds it under stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && frame_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && frame_end) begin
            m_data_reg <= report;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `KMRB_ASSERT_NEXT(a_frame_reports, aclk, aresetn, accept && frame_end, m_tvalid)
    `KMRB_ASSERT_IMP(a_stall_blocks, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `KMRB_ASSERT_NEXT(a_row_no_report, aclk, aresetn, accept && !frame_end, !m_tvalid)

endmodule
